// File: src/cfvg_pkg.sv
// ----------------------------------------------------------------------------
// cfvg_pkg
// Shared constants, types and the CORDIC arctangent table of the fan vertex
// generator.
// ----------------------------------------------------------------------------
package cfvg_pkg;

  localparam int unsigned SegmentBitsDef  = 12;
  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned AtanEntries     = 24;
  localparam int unsigned QueueDepth      = 4;

  localparam logic [1:0] RegRadius  = 2'd0;
  localparam logic [1:0] RegSegs    = 2'd1;
  localparam logic [1:0] RegStart   = 2'd2;
  localparam logic [1:0] RegSweep   = 2'd3;

  localparam logic signed [33:0] GainQ30 = 34'sd652032874;
  localparam logic signed [33:0] OneQ30  = 34'sd1073741824;

  // Vertex class decided by the front end
  typedef enum logic [1:0] {
    VtxCenter = 2'd0,
    VtxRim    = 2'd1,
    VtxOutside = 2'd2
  } vtx_kind_e;

  function automatic logic [31:0] atan_turn(input int unsigned idx);
    logic [31:0] tab [AtanEntries];
    tab = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
            32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
            32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};
    return tab[idx];
  endfunction

endpackage

// File: src/circle_fan_vertex_generator_unit.sv
// ----------------------------------------------------------------------------
// circle_fan_vertex_generator_unit
// Circle / arc triangle-fan vertex generator: position and texture coordinate.
// ----------------------------------------------------------------------------
// A vertex passes the front end (multiply register, one divider stage per
//   quotient bit), queue, back end (input, CORDIC, scale, output registers).
// Throughput: one vertex per clock, set by the fully pipelined divider and
//   CORDIC; busy stays low.
// Reset: clears all valid bits and loads the register defaults.
module circle_fan_vertex_generator_unit #(
  parameter int unsigned SegmentBits  = cfvg_pkg::SegmentBitsDef,
  parameter int unsigned CordicStages = cfvg_pkg::CordicStagesDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [SegmentBits:0]   vertex_number_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [16:0]            cfg_data_i,
  output logic                   done_o,
  output logic signed [16:0]     pos_x_o,
  output logic signed [16:0]     pos_y_o,
  output logic [15:0]            tex_u_o,
  output logic [15:0]            tex_v_o,
  output logic                   out_of_range_o
);

  logic [15:0]            radius_q;
  logic [SegmentBits-1:0] segs_q;
  logic [15:0]            start_q;
  logic [16:0]            sweep_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd256;
      segs_q   <= SegmentBits'(8);
      start_q  <= '0;
      sweep_q  <= 17'h10000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cfvg_pkg::RegRadius: radius_q <= cfg_data_i[15:0];
        cfvg_pkg::RegSegs:   segs_q   <= cfg_data_i[SegmentBits-1:0];
        cfvg_pkg::RegStart:  start_q  <= cfg_data_i[15:0];
        cfvg_pkg::RegSweep:  sweep_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic                f_valid;
  cfvg_pkg::vtx_kind_e f_kind;
  logic [15:0]         f_angle;

  cfvg_front #(.SegmentBits(SegmentBits)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i      (start && !busy),
    .vertex_number_i,
    .segment_count_i (segs_q),
    .start_angle_i   (start_q),
    .sweep_angle_i   (sweep_q),
    .out_valid_o     (f_valid),
    .out_kind_o      (f_kind),
    .out_angle_o     (f_angle)
  );

  logic        q_empty;
  logic [17:0] q_data;

  // Back end never stalls, so pop whatever is present
  cfvg_queue #(.Width(18)) u_queue (
    .clk_i, .rst_ni,
    .push_i      (f_valid),
    .push_data_i ({f_kind, f_angle}),
    .pop_i       (!q_empty),
    .empty_o     (q_empty),
    .pop_data_o  (q_data)
  );

  cfvg_back #(.CordicStages(CordicStages)) u_back (
    .clk_i, .rst_ni,
    .in_valid_i     (!q_empty),
    .in_kind_i      (cfvg_pkg::vtx_kind_e'(q_data[17:16])),
    .in_angle_i     (q_data[15:0]),
    .radius_i       (radius_q),
    .done_o, .pos_x_o, .pos_y_o, .tex_u_o, .tex_v_o, .out_of_range_o
  );

  a_oor_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_of_range_o |-> pos_x_o == '0 && pos_y_o == '0 && tex_u_o == '0)
    else $error("out-of-range vertex with nonzero payload");

  a_tex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> tex_u_o <= 16'd32768 && tex_v_o <= 16'd32768)
    else $error("texture coordinate above 1.0");

  a_queue_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_empty |=> $past(f_valid) || q_empty || $past(!q_empty))
    else $error("queue state inconsistent");

endmodule

// File: src/cfvg_front.sv
// ----------------------------------------------------------------------------
// cfvg_front
// Classifies a vertex number and computes its angle offset as
// (k-1)*sweep/segs with a pipelined restoring divider, one quotient bit a
// stage.
// ----------------------------------------------------------------------------
module cfvg_front #(
  parameter int unsigned SegmentBits = cfvg_pkg::SegmentBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [SegmentBits:0]   vertex_number_i,
  input  logic [SegmentBits-1:0] segment_count_i,
  input  logic [15:0]            start_angle_i,
  input  logic [16:0]            sweep_angle_i,
  output logic                   out_valid_o,
  output cfvg_pkg::vtx_kind_e    out_kind_o,
  output logic [15:0]            out_angle_o
);

  localparam int unsigned PW = SegmentBits + 17;   // product width
  localparam int unsigned NS = PW;                 // one stage per quotient bit

  logic [SegmentBits-1:0] segs;
  logic [SegmentBits:0]   k_m1;
  logic                   outside;

  always_comb begin
    segs    = (segment_count_i < SegmentBits'(3)) ? SegmentBits'(3) : segment_count_i;
    k_m1    = vertex_number_i - 1'b1;
    outside = ({1'b0, vertex_number_i} > ({2'b00, segs} + (SegmentBits+2)'(1)));
  end

  // Multiply stage
  logic                   m_valid_q;
  cfvg_pkg::vtx_kind_e    m_kind_q;
  logic [PW-1:0]          m_prod_q;
  logic [SegmentBits-1:0] m_segs_q;
  logic [15:0]            m_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vertex_number_i == '0) m_kind_q <= cfvg_pkg::VtxCenter;
    else if (outside)          m_kind_q <= cfvg_pkg::VtxOutside;
    else                       m_kind_q <= cfvg_pkg::VtxRim;
    m_prod_q  <= PW'(k_m1) * PW'(sweep_angle_i);
    m_segs_q  <= segs;
    m_start_q <= start_angle_i;
  end

  // Divider stages: stage i produces quotient bit NS-1-i
  logic                   d_valid_q [NS+1];
  cfvg_pkg::vtx_kind_e    d_kind_q  [NS+1];
  logic [PW-1:0]          d_num_q   [NS+1];
  logic [SegmentBits:0]   d_rem_q   [NS+1];
  logic [PW-1:0]          d_quo_q   [NS+1];
  logic [SegmentBits-1:0] d_segs_q  [NS+1];
  logic [15:0]            d_start_q [NS+1];

  always_comb begin
    d_valid_q[0] = m_valid_q;
    d_kind_q[0]  = m_kind_q;
    d_num_q[0]   = m_prod_q;
    d_rem_q[0]   = '0;
    d_quo_q[0]   = '0;
    d_segs_q[0]  = m_segs_q;
    d_start_q[0] = m_start_q;
  end

  for (genvar i = 0; i < NS; i++) begin : g_div
    logic [SegmentBits+1:0] trial;
    logic [SegmentBits+1:0] diff;
    assign trial = {d_rem_q[i], d_num_q[i][PW-1]};
    assign diff  = trial - {2'b00, d_segs_q[i]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_valid_q[i+1] <= 1'b0;
      end else begin
        d_valid_q[i+1] <= d_valid_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      d_kind_q[i+1]  <= d_kind_q[i];
      d_num_q[i+1]   <= {d_num_q[i][PW-2:0], 1'b0};
      d_segs_q[i+1]  <= d_segs_q[i];
      d_start_q[i+1] <= d_start_q[i];
      if (!diff[SegmentBits+1]) begin
        d_rem_q[i+1] <= diff[SegmentBits:0];
        d_quo_q[i+1] <= {d_quo_q[i][PW-2:0], 1'b1};
      end else begin
        d_rem_q[i+1] <= trial[SegmentBits:0];
        d_quo_q[i+1] <= {d_quo_q[i][PW-2:0], 1'b0};
      end
    end
  end

  assign out_valid_o = d_valid_q[NS];
  assign out_kind_o  = d_kind_q[NS];
  assign out_angle_o = d_start_q[NS] + d_quo_q[NS][15:0];

endmodule

// File: src/cfvg_queue.sv
// ----------------------------------------------------------------------------
// cfvg_queue
// Short FIFO between the angle front end and the CORDIC back end.
// ----------------------------------------------------------------------------
module cfvg_queue #(
  parameter int unsigned Width = 18,
  parameter int unsigned Depth = cfvg_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

endmodule

// File: src/cfvg_back.sv
// ----------------------------------------------------------------------------
// cfvg_back
// Pipelined CORDIC in rotation mode followed by radius scaling and texture
// coordinate rounding.
// ----------------------------------------------------------------------------
module cfvg_back #(
  parameter int unsigned CordicStages = cfvg_pkg::CordicStagesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  cfvg_pkg::vtx_kind_e in_kind_i,
  input  logic [15:0]         in_angle_i,
  input  logic [15:0]         radius_i,
  output logic                done_o,
  output logic signed [16:0]  pos_x_o,
  output logic signed [16:0]  pos_y_o,
  output logic [15:0]         tex_u_o,
  output logic [15:0]         tex_v_o,
  output logic                out_of_range_o
);

  localparam int unsigned NS = CordicStages;

  logic                   c_valid_q [NS+1];
  cfvg_pkg::vtx_kind_e    c_kind_q  [NS+1];
  logic signed [33:0]     c_x_q     [NS+1];
  logic signed [33:0]     c_y_q     [NS+1];
  logic signed [33:0]     c_z_q     [NS+1];
  logic [15:0]            c_rad_q   [NS+1];

  // Fold into +-quarter turn
  logic signed [33:0] z0;
  logic               flip;
  always_comb begin
    z0   = 34'(signed'({in_angle_i, 16'h0000}));
    flip = 1'b0;
    if (z0 > 34'sh40000000) begin
      z0   = z0 - 34'sh80000000;
      flip = 1'b1;
    end else if (z0 < -34'sh40000000) begin
      z0   = z0 + 34'sh80000000;
      flip = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q[0] <= 1'b0;
    end else begin
      c_valid_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    c_kind_q[0] <= in_kind_i;
    c_x_q[0]    <= flip ? -cfvg_pkg::GainQ30 : cfvg_pkg::GainQ30;
    c_y_q[0]    <= '0;
    c_z_q[0]    <= z0;
    c_rad_q[0]  <= radius_i;
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    localparam logic signed [33:0] Atan =
      (i < cfvg_pkg::AtanEntries) ? 34'(cfvg_pkg::atan_turn(i)) : 34'sd0;
    logic signed [33:0] dx, dy;
    assign dx = c_y_q[i] >>> i;
    assign dy = c_x_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        c_valid_q[i+1] <= 1'b0;
      end else begin
        c_valid_q[i+1] <= c_valid_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      c_kind_q[i+1] <= c_kind_q[i];
      c_rad_q[i+1]  <= c_rad_q[i];
      if (i >= cfvg_pkg::AtanEntries) begin
        c_x_q[i+1] <= c_x_q[i];
        c_y_q[i+1] <= c_y_q[i];
        c_z_q[i+1] <= c_z_q[i];
      end else if (!c_z_q[i][33]) begin
        c_x_q[i+1] <= c_x_q[i] - dx;
        c_y_q[i+1] <= c_y_q[i] + dy;
        c_z_q[i+1] <= c_z_q[i] - Atan;
      end else begin
        c_x_q[i+1] <= c_x_q[i] + dx;
        c_y_q[i+1] <= c_y_q[i] - dy;
        c_z_q[i+1] <= c_z_q[i] + Atan;
      end
    end
  end

  // Clamp, then scale by radius
  logic signed [31:0] cc, ss;
  always_comb begin
    if (c_x_q[NS] > cfvg_pkg::OneQ30)       cc = 32'(cfvg_pkg::OneQ30);
    else if (c_x_q[NS] < -cfvg_pkg::OneQ30) cc = 32'(-cfvg_pkg::OneQ30);
    else                                    cc = c_x_q[NS][31:0];
    if (c_y_q[NS] > cfvg_pkg::OneQ30)       ss = 32'(cfvg_pkg::OneQ30);
    else if (c_y_q[NS] < -cfvg_pkg::OneQ30) ss = 32'(-cfvg_pkg::OneQ30);
    else                                    ss = c_y_q[NS][31:0];
  end

  logic                s_valid_q;
  cfvg_pkg::vtx_kind_e s_kind_q;
  logic signed [48:0]  s_px_q, s_py_q;
  logic signed [31:0]  s_c_q, s_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= c_valid_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    s_kind_q <= c_kind_q[NS];
    s_px_q   <= $signed({1'b0, c_rad_q[NS]}) * cc;
    s_py_q   <= $signed({1'b0, c_rad_q[NS]}) * ss;
    s_c_q    <= cc;
    s_s_q    <= ss;
  end

  logic signed [48:0] px_r, py_r;
  logic [32:0]        tu_r, tv_r;
  assign px_r = s_px_q + 49'sd536870912;
  assign py_r = s_py_q + 49'sd536870912;
  assign tu_r = 33'(s_c_q + 33'sd1073741824 + 33'sd32768);
  assign tv_r = 33'(s_s_q + 33'sd1073741824 + 33'sd32768);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= s_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (s_kind_q)
      cfvg_pkg::VtxCenter: begin
        pos_x_o <= '0; pos_y_o <= '0;
        tex_u_o <= 16'd16384; tex_v_o <= 16'd16384;
        out_of_range_o <= 1'b0;
      end
      cfvg_pkg::VtxRim: begin
        pos_x_o <= px_r[46:30]; pos_y_o <= py_r[46:30];
        tex_u_o <= tu_r[31:16]; tex_v_o <= tv_r[31:16];
        out_of_range_o <= 1'b0;
      end
      default: begin
        pos_x_o <= '0; pos_y_o <= '0;
        tex_u_o <= '0; tex_v_o <= '0;
        out_of_range_o <= 1'b1;
      end
    endcase
  end

endmodule
